// File: src/kqs_pkg.sv
// ----------------------------------------------------------------------------
// kqs_pkg: shared types and constants for the key quicksort engine
// Beat structures for both channels, the range stack entry and its command.
// ----------------------------------------------------------------------------
`default_nettype none

package kqs_pkg;

  localparam int KEY_W       = 16;
  localparam int PASS_W      = 6;
  localparam int RANGE_W     = 8;
  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = 4;
  localparam int SP_W        = 5;

  localparam logic [PASS_W-1:0] PASS_MAX = 6'd63;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last_item;
  } in_beat_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic                    end_of_set;
    logic [PASS_W-1:0]       partition_passes;
    logic                    overflow;
  } out_beat_t;

  typedef struct packed {
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
  } range_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    range_t rng;
  } stk_cmd_t;

endpackage

`default_nettype wire

// File: src/kqs_key_ram.sv
// ----------------------------------------------------------------------------
// kqs_key_ram: key store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kqs_key_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [AW-1:0]                   waddr,
  input  wire logic signed [kqs_pkg::KEY_W-1:0] wdata,
  input  wire logic [AW-1:0]                   raddr,
  output      logic signed [kqs_pkg::KEY_W-1:0] rdata
);
  import kqs_pkg::*;

  logic signed [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/kqs_range_stack.sv
// ----------------------------------------------------------------------------
// kqs_range_stack: pending range stack
// Holds (low, high) ranges awaiting a partition pass; top entry is visible.
// ----------------------------------------------------------------------------
`default_nettype none

module kqs_range_stack (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kqs_pkg::stk_cmd_t cmd,
  output      kqs_pkg::range_t   top,
  output      logic              empty
);
  import kqs_pkg::*;

  range_t          entry_r [STACK_DEPTH];
  logic [SP_W-1:0] sp_r;
  logic [SP_W-1:0] sp_nxt;
  logic [SP_W-1:0] sp_dec;
  logic            full;

  assign full   = (sp_r == SP_W'(STACK_DEPTH));
  assign empty  = (sp_r == '0);
  assign sp_dec = sp_r - SP_W'(1);
  assign top    = entry_r[sp_dec[STK_AW-1:0]];

  always_comb begin
    sp_nxt = sp_r;
    if (cmd.push && !full) begin
      sp_nxt = sp_r + SP_W'(1);
    end else if (cmd.pop && !empty) begin
      sp_nxt = sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      entry_r[sp_r[STK_AW-1:0]] <= cmd.rng;
    end
  end

endmodule

`default_nettype wire

// File: src/key_quicksort_engine_top.sv
// ----------------------------------------------------------------------------
// key_quicksort_engine_top: key loader, quicksort sequencer and sorted output
// Loading takes one cycle per key beat; the sort starts after a last_item beat.
// Each partition pass scans its range through the single read port of the key
// store and compares each key read against the pivot. Output reads, captures
// and presents one key at a time (S_ERD, S_ECAP, S_EOUT), waiting for out_ready.
// Synchronous active-low reset empties the set; the key store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module key_quicksort_engine_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire kqs_pkg::in_beat_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      kqs_pkg::out_beat_t out_data
);
  import kqs_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_PIV   = 4'd3;
  localparam logic [3:0] S_RSCAN = 4'd4;
  localparam logic [3:0] S_LSCAN = 4'd5;
  localparam logic [3:0] S_PUSHA = 4'd6;
  localparam logic [3:0] S_PUSHB = 4'd7;
  localparam logic [3:0] S_ERD   = 4'd8;
  localparam logic [3:0] S_ECAP  = 4'd9;
  localparam logic [3:0] S_EOUT  = 4'd10;

  logic [3:0]              state_r,    state_nxt;
  logic [CW-1:0]           fill_r,     fill_nxt;
  logic                    dropped_r,  dropped_nxt;
  logic [PASS_W-1:0]       pass_r,     pass_nxt;
  logic [IW-1:0]           lo_r,       lo_nxt;
  logic [IW-1:0]           hi_r,       hi_nxt;
  logic [IW-1:0]           a_r,        a_nxt;
  logic [IW-1:0]           b_r,        b_nxt;
  logic [IW-1:0]           k_r,        k_nxt;
  logic signed [KEY_W-1:0] pivot_r,    pivot_nxt;
  out_beat_t               out_r,      out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic signed [KEY_W-1:0] ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic signed [KEY_W-1:0] ram_rdata;

  stk_cmd_t                stk_cmd;
  range_t                  stk_top;
  logic                    stk_empty;

  // Compares of the read key against the pivot, one for each scan direction.
  logic                    key_ge, key_le;
  // Subrange bookkeeping after a pass, pivot at a_r.
  logic [IW:0]             p_ext, lo_ext, hi_ext;
  logic                    left_ok, right_ok, left_first;
  range_t                  left_rng, right_rng;

  assign key_ge = (ram_rdata >= pivot_r);
  assign key_le = (ram_rdata <= pivot_r);

  assign p_ext      = {1'b0, a_r};
  assign lo_ext     = {1'b0, lo_r};
  assign hi_ext     = {1'b0, hi_r};
  assign left_ok    = (p_ext > lo_ext + (IW+1)'(1));
  assign right_ok   = (p_ext + (IW+1)'(1) < hi_ext);
  assign left_first = ((p_ext - lo_ext) >= (hi_ext - p_ext));
  assign left_rng   = '{lo: RANGE_W'(lo_r), hi: RANGE_W'(a_r - IW'(1))};
  assign right_rng  = '{lo: RANGE_W'(a_r + IW'(1)), hi: RANGE_W'(hi_r)};

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    dropped_nxt   = dropped_r;
    pass_nxt      = pass_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = a_r;
    ram_wdata     = pivot_r;
    ram_raddr     = '0;
    stk_cmd       = '0;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (fill_r < CW'(CAPACITY)) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[IW-1:0];
            ram_wdata = in_data.key;
            fill_nxt  = fill_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (fill_r >= CW'(2)) begin
          stk_cmd.push   = 1'b1;
          stk_cmd.rng.lo = '0;
          stk_cmd.rng.hi = RANGE_W'(fill_r - CW'(1));
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (stk_empty) begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          stk_cmd.pop = 1'b1;
          lo_nxt      = stk_top.lo[IW-1:0];
          hi_nxt      = stk_top.hi[IW-1:0];
          ram_raddr   = stk_top.lo[IW-1:0];
          if (pass_r < PASS_MAX) begin
            pass_nxt = pass_r + PASS_W'(1);
          end
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        pivot_nxt = ram_rdata;
        a_nxt     = lo_r;
        b_nxt     = hi_r;
        ram_raddr = hi_r;
        state_nxt = S_RSCAN;
      end
      S_RSCAN: begin
        // Read data holds the key at b_r.
        if ((b_r > a_r) && key_ge) begin
          b_nxt     = b_r - IW'(1);
          ram_raddr = b_r - IW'(1);
        end else if (a_r < b_r) begin
          // The moved key is below the pivot, so the left scan steps once at once.
          ram_we    = 1'b1;
          ram_waddr = a_r;
          ram_wdata = ram_rdata;
          a_nxt     = a_r + IW'(1);
          ram_raddr = a_r + IW'(1);
          state_nxt = S_LSCAN;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = a_r;
          ram_wdata = pivot_r;
          state_nxt = S_PUSHA;
        end
      end
      S_LSCAN: begin
        // Read data holds the key at a_r.
        if ((a_r < b_r) && key_le) begin
          a_nxt     = a_r + IW'(1);
          ram_raddr = a_r + IW'(1);
        end else if (a_r < b_r) begin
          ram_we    = 1'b1;
          ram_waddr = b_r;
          ram_wdata = ram_rdata;
          b_nxt     = b_r - IW'(1);
          ram_raddr = b_r - IW'(1);
          state_nxt = S_RSCAN;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = a_r;
          ram_wdata = pivot_r;
          state_nxt = S_PUSHA;
        end
      end
      S_PUSHA: begin
        // The larger subrange goes on first so the smaller is split next.
        if (left_first) begin
          stk_cmd.push = left_ok;
          stk_cmd.rng  = left_rng;
        end else begin
          stk_cmd.push = right_ok;
          stk_cmd.rng  = right_rng;
        end
        state_nxt = S_PUSHB;
      end
      S_PUSHB: begin
        if (left_first) begin
          stk_cmd.push = right_ok;
          stk_cmd.rng  = right_rng;
        end else begin
          stk_cmd.push = left_ok;
          stk_cmd.rng  = left_rng;
        end
        state_nxt = S_POP;
      end
      S_ERD: begin
        ram_raddr = k_r;
        state_nxt = S_ECAP;
      end
      S_ECAP: begin
        out_nxt.sorted_key       = ram_rdata;
        out_nxt.end_of_set       = ((CW'(k_r) + CW'(1)) == fill_r);
        out_nxt.partition_passes = pass_r;
        out_nxt.overflow         = dropped_r;
        out_valid_nxt            = 1'b1;
        state_nxt                = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.end_of_set) begin
            fill_nxt    = '0;
            pass_nxt    = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      dropped_r   <= dropped_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    pivot_r <= pivot_nxt;
    out_r   <= out_nxt;
  end

  kqs_key_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kqs_range_stack u_range_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .top   (stk_top),
    .empty (stk_empty)
  );

endmodule

`default_nettype wire
